// ===== rtl/core/keypad_four_function_calculator_top_macros.svh =====
// Assertion macros shared by the calculator RTL.
`ifndef KEYPAD_FOUR_FUNCTION_CALCULATOR_TOP_MACROS_SVH
`define KEYPAD_FOUR_FUNCTION_CALCULATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define KC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("calculator assertion failed");
`define KC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calculator assertion failed");
`else
`define KC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define KC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/kcalc_pkg.sv =====
// Types, codes and the microprogram of the keypad calculator.
`timescale 1ns / 1ps
package kcalc_pkg;

    localparam int KC_VALUE_WIDTH = 32;
    localparam int KC_DISP_W      = 32;

    // Key kinds.
    localparam logic [1:0] KEY_DIGIT = 2'd0;
    localparam logic [1:0] KEY_OPER  = 2'd1;
    localparam logic [1:0] KEY_CLEAR = 2'd2;

    // Operation codes.
    localparam logic [2:0] OPR_NONE   = 3'd0;
    localparam logic [2:0] OPR_PLUS   = 3'd1;
    localparam logic [2:0] OPR_MINUS  = 3'd2;
    localparam logic [2:0] OPR_MUL    = 3'd3;
    localparam logic [2:0] OPR_DIV    = 3'd4;
    localparam logic [2:0] OPR_EQUALS = 3'd5;

    typedef logic [3:0] t_dp_op;
    typedef logic [2:0] t_cond;
    typedef logic [3:0] t_addr;

    // Datapath operations.
    localparam t_dp_op DP_NOP   = 4'd0;
    localparam t_dp_op DP_DIG1  = 4'd1;
    localparam t_dp_op DP_DIG2  = 4'd2;
    localparam t_dp_op DP_ADD   = 4'd3;
    localparam t_dp_op DP_SUB   = 4'd4;
    localparam t_dp_op DP_COPY  = 4'd5;
    localparam t_dp_op DP_MSET  = 4'd6;
    localparam t_dp_op DP_MSTEP = 4'd7;
    localparam t_dp_op DP_MEND  = 4'd8;
    localparam t_dp_op DP_DSET  = 4'd9;
    localparam t_dp_op DP_DSTEP = 4'd10;
    localparam t_dp_op DP_DEND  = 4'd11;
    localparam t_dp_op DP_FIN   = 4'd12;
    localparam t_dp_op DP_OUT   = 4'd13;
    localparam t_dp_op DP_CLR   = 4'd14;

    // Sequencer branch conditions.
    localparam t_cond C_NEXT   = 3'd0;
    localparam t_cond C_JUMP   = 3'd1;
    localparam t_cond C_ACCEPT = 3'd2;
    localparam t_cond C_LOOP   = 3'd3;
    localparam t_cond C_ZERO   = 3'd4;
    localparam t_cond C_OUT    = 3'd5;

    // Microprogram addresses.
    localparam t_addr A_IDLE  = 4'd0;
    localparam t_addr A_DIG1  = 4'd1;
    localparam t_addr A_DIG2  = 4'd2;
    localparam t_addr A_ADD   = 4'd3;
    localparam t_addr A_SUB   = 4'd4;
    localparam t_addr A_COPY  = 4'd5;
    localparam t_addr A_MSET  = 4'd6;
    localparam t_addr A_MLOOP = 4'd7;
    localparam t_addr A_MEND  = 4'd8;
    localparam t_addr A_DSET  = 4'd9;
    localparam t_addr A_DLOOP = 4'd10;
    localparam t_addr A_DEND  = 4'd11;
    localparam t_addr A_FIN   = 4'd12;
    localparam t_addr A_OUT   = 4'd13;
    localparam t_addr A_CLR   = 4'd14;

    typedef struct packed {
        t_dp_op dp_op;
        t_cond  cond;
        t_addr  target;
    } t_uword;

    typedef struct packed {
        logic   load;
        t_dp_op dp_op;
    } t_ctl;

    typedef struct packed {
        logic       entry_zero;
        logic       out_free;
        logic [2:0] stored_op;
    } t_stat;

    function automatic t_uword kc_urom(input t_addr pc);
        t_uword w;
        w = '{dp_op: DP_NOP, cond: C_JUMP, target: A_IDLE};
        case (pc)
            A_IDLE:  w = '{dp_op: DP_NOP,   cond: C_ACCEPT, target: A_IDLE};
            A_DIG1:  w = '{dp_op: DP_DIG1,  cond: C_NEXT,   target: A_IDLE};
            A_DIG2:  w = '{dp_op: DP_DIG2,  cond: C_JUMP,   target: A_OUT};
            A_ADD:   w = '{dp_op: DP_ADD,   cond: C_JUMP,   target: A_FIN};
            A_SUB:   w = '{dp_op: DP_SUB,   cond: C_JUMP,   target: A_FIN};
            A_COPY:  w = '{dp_op: DP_COPY,  cond: C_JUMP,   target: A_FIN};
            A_MSET:  w = '{dp_op: DP_MSET,  cond: C_NEXT,   target: A_IDLE};
            A_MLOOP: w = '{dp_op: DP_MSTEP, cond: C_LOOP,   target: A_MLOOP};
            A_MEND:  w = '{dp_op: DP_MEND,  cond: C_JUMP,   target: A_FIN};
            A_DSET:  w = '{dp_op: DP_DSET,  cond: C_ZERO,   target: A_FIN};
            A_DLOOP: w = '{dp_op: DP_DSTEP, cond: C_LOOP,   target: A_DLOOP};
            A_DEND:  w = '{dp_op: DP_DEND,  cond: C_NEXT,   target: A_IDLE};
            A_FIN:   w = '{dp_op: DP_FIN,   cond: C_NEXT,   target: A_IDLE};
            A_OUT:   w = '{dp_op: DP_OUT,   cond: C_OUT,    target: A_IDLE};
            A_CLR:   w = '{dp_op: DP_CLR,   cond: C_JUMP,   target: A_OUT};
            default: w = '{dp_op: DP_NOP,   cond: C_JUMP,   target: A_IDLE};
        endcase
        return w;
    endfunction

    // Entry point of the program for a newly accepted key.
    function automatic t_addr kc_dispatch(input logic [1:0] kind, input logic [2:0] oper,
                                          input logic [2:0] stored);
        t_addr a;
        a = A_OUT;
        case (kind)
            KEY_DIGIT: a = A_DIG1;
            KEY_CLEAR: a = A_CLR;
            KEY_OPER: begin
                if (oper >= OPR_PLUS && oper <= OPR_EQUALS) begin
                    case (stored)
                        OPR_PLUS:  a = A_ADD;
                        OPR_MINUS: a = A_SUB;
                        OPR_MUL:   a = A_MSET;
                        OPR_DIV:   a = A_DSET;
                        default:   a = A_COPY;
                    endcase
                end
            end
            default: a = A_OUT;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/core/kcalc_seq.sv =====
// Microcode sequencer: program counter, loop counter and control ROM.
`timescale 1ns / 1ps
`include "keypad_four_function_calculator_top_macros.svh"
module kcalc_seq
    import kcalc_pkg::*;
#(
    parameter int VALUE_WIDTH = KC_VALUE_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_op,
    input  logic [2:0] i_operation,
    input  t_stat      i_stat,
    output logic       o_stall,
    output t_ctl       o_ctl
);

    localparam int CNT_W = $clog2(VALUE_WIDTH);

    logic [3:0]       r_pc;
    logic [3:0]       n_pc;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    t_uword           uw;
    logic             accept;
    logic             last;

    assign uw      = kc_urom(r_pc);
    assign o_stall = (r_pc != A_IDLE);
    assign accept  = i_valid && (r_pc == A_IDLE);
    assign last    = (r_cnt == CNT_W'(VALUE_WIDTH - 1));

    always_comb begin
        o_ctl.load  = accept;
        o_ctl.dp_op = uw.dp_op;
        // The result step only fires once the output register can take it.
        if (uw.cond == C_OUT && !i_stat.out_free) begin
            o_ctl.dp_op = DP_NOP;
        end
    end

    always_comb begin
        n_pc  = r_pc;
        n_cnt = '0;
        case (uw.cond)
            C_NEXT:   n_pc = r_pc + 4'd1;
            C_JUMP:   n_pc = uw.target;
            C_ACCEPT: n_pc = accept ? kc_dispatch(i_op, i_operation, i_stat.stored_op) : r_pc;
            C_LOOP: begin
                n_pc  = last ? r_pc + 4'd1 : uw.target;
                n_cnt = last ? '0 : r_cnt + 1'b1;
            end
            C_ZERO:   n_pc = i_stat.entry_zero ? uw.target : r_pc + 4'd1;
            C_OUT:    n_pc = i_stat.out_free ? uw.target : r_pc;
            default:  n_pc = A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= A_IDLE;
            r_cnt <= '0;
        end else begin
            r_pc  <= n_pc;
            r_cnt <= n_cnt;
        end
    end

    `KC_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, accept, r_pc != A_IDLE)
    `KC_ASSERT_SAME(a_cnt_only_in_loop, i_clk, i_rst_n, r_cnt != '0,
                    r_pc == A_MLOOP || r_pc == A_DLOOP)
    `KC_ASSERT_NEXT(a_out_waits, i_clk, i_rst_n, r_pc == A_OUT && !i_stat.out_free,
                    r_pc == A_OUT)

endmodule

// ===== rtl/core/kcalc_dp.sv =====
// Calculator datapath: state registers, shared adder work registers and result register.
`timescale 1ns / 1ps
`include "keypad_four_function_calculator_top_macros.svh"
module kcalc_dp
    import kcalc_pkg::*;
#(
    parameter int VALUE_WIDTH = KC_VALUE_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_ctl                        i_ctl,
    input  logic [3:0]                  i_digit,
    input  logic [2:0]                  i_operation,
    input  logic                        i_stall,
    output t_stat                       o_stat,
    output logic                        o_valid,
    output logic signed [KC_DISP_W-1:0] o_display,
    output logic [2:0]                  o_pending_op,
    output logic                        o_div_by_zero
);

    localparam int W = VALUE_WIDTH;

    logic [W-1:0] r_total;
    logic [W-1:0] r_entry;
    logic [2:0]   r_stored_op;
    logic         r_show_total;
    logic [W-1:0] r_a;
    logic [W-1:0] r_b;
    logic [W-1:0] r_d;
    logic         r_neg;
    logic         r_dz;
    logic [3:0]   r_digit;
    logic [2:0]   r_oper;
    logic         r_out_valid;

    logic [W-1:0] shown;
    logic [W-1:0] rem;
    logic [W:0]   diff;
    logic         out_free;
    logic [KC_DISP_W-1:0] shown_ext;

    assign shown    = r_show_total ? r_total : r_entry;
    assign rem      = {r_a[W-2:0], r_b[W-1]};
    assign diff     = {1'b0, rem} - {1'b0, r_d};
    assign out_free = !r_out_valid || !i_stall;

    generate
        if (W >= KC_DISP_W) begin : g_trunc
            assign shown_ext = shown[KC_DISP_W-1:0];
        end else begin : g_ext
            assign shown_ext = {{(KC_DISP_W - W){1'b0}}, shown};
        end
    endgenerate

    always_comb begin
        o_stat.entry_zero = (r_entry == '0);
        o_stat.out_free   = out_free;
        o_stat.stored_op  = r_stored_op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total      <= '0;
            r_entry      <= '0;
            r_stored_op  <= OPR_NONE;
            r_show_total <= 1'b1;
            r_dz         <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_ctl.load) begin
                r_digit <= i_digit;
                r_oper  <= i_operation;
                r_dz    <= 1'b0;
            end
            if (i_ctl.dp_op == DP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (i_ctl.dp_op)
                DP_DIG1: r_a <= {r_entry[W-4:0], 3'b000} + W'(r_digit);
                DP_DIG2: begin
                    r_entry      <= r_a + {r_entry[W-2:0], 1'b0};
                    r_show_total <= 1'b0;
                end
                DP_ADD:  r_total <= r_total + r_entry;
                DP_SUB:  r_total <= r_total - r_entry;
                DP_COPY: r_total <= r_entry;
                DP_MSET: begin
                    r_a <= '0;
                    r_b <= r_entry;
                end
                DP_MSTEP: begin
                    // Most significant multiplier bit first.
                    r_a <= {r_a[W-2:0], 1'b0} + (r_b[W-1] ? r_total : '0);
                    r_b <= {r_b[W-2:0], 1'b0};
                end
                DP_MEND: r_total <= r_a;
                DP_DSET: begin
                    r_a   <= '0;
                    r_b   <= r_total[W-1] ? '0 - r_total : r_total;
                    r_d   <= r_entry[W-1] ? '0 - r_entry : r_entry;
                    r_neg <= r_total[W-1] ^ r_entry[W-1];
                    r_dz  <= (r_entry == '0);
                end
                DP_DSTEP: begin
                    // Restoring division on magnitudes; quotient bits enter r_b.
                    if (!diff[W]) begin
                        r_a <= diff[W-1:0];
                        r_b <= {r_b[W-2:0], 1'b1};
                    end else begin
                        r_a <= rem;
                        r_b <= {r_b[W-2:0], 1'b0};
                    end
                end
                DP_DEND: r_total <= r_neg ? '0 - r_b : r_b;
                DP_FIN: begin
                    r_entry      <= '0;
                    r_show_total <= 1'b1;
                    r_stored_op  <= r_oper;
                end
                DP_OUT: begin
                    o_display     <= shown_ext;
                    o_pending_op  <= r_stored_op;
                    o_div_by_zero <= r_dz;
                end
                DP_CLR: begin
                    r_total      <= '0;
                    r_entry      <= '0;
                    r_stored_op  <= OPR_NONE;
                    r_show_total <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;

    `KC_ASSERT_SAME(a_out_load_free, i_clk, i_rst_n, i_ctl.dp_op == DP_OUT, out_free)
    `KC_ASSERT_NEXT(a_load_clears_dz, i_clk, i_rst_n, i_ctl.load, !r_dz)
    `KC_ASSERT_NEXT(a_out_sets_valid, i_clk, i_rst_n, i_ctl.dp_op == DP_OUT, r_out_valid)

endmodule

// ===== rtl/core/keypad_four_function_calculator_top.sv =====
// Top level of the keypad four-function calculator.
//
//   channel  direction  handshake           payload
//   key      in         i_valid / o_stall   i_op, i_digit, i_operation
//   result   out        o_valid / i_stall   o_display, o_pending_op, o_div_by_zero
//
// One key is processed at a time by a microcoded sequencer over a shared datapath.
// Each key ends in the result step: a digit after two digit steps, add, subtract or copy after
// its step and a finish step, clear after a clear step, an ignored key at once; multiply and
// divide run set-up, a one-bit-per-cycle loop, end and finish (division by zero skips to finish).
// The result sits in an output register, so the next key is accepted while it waits.
// Synchronous active-low reset clears total and entry, selects the total and idles the sequencer.
// A stalled result holds the sequencer at its result step until the register frees.
`timescale 1ns / 1ps
module keypad_four_function_calculator_top
    import kcalc_pkg::*;
#(
    parameter int VALUE_WIDTH = KC_VALUE_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_op,
    input  logic [3:0]                  i_digit,
    input  logic [2:0]                  i_operation,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [KC_DISP_W-1:0] o_display,
    output logic [2:0]                  o_pending_op,
    output logic                        o_div_by_zero
);

    t_ctl  ctl;
    t_stat stat;

    kcalc_seq #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_op        (i_op),
        .i_operation (i_operation),
        .i_stat      (stat),
        .o_stall     (o_stall),
        .o_ctl       (ctl)
    );

    kcalc_dp #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_digit       (i_digit),
        .i_operation   (i_operation),
        .i_stall       (i_stall),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .o_display     (o_display),
        .o_pending_op  (o_pending_op),
        .o_div_by_zero (o_div_by_zero)
    );

endmodule
